// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks on the rising clock edge, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RHFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("rhfr assertion failed");

`define RHFR_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("rhfr forbidden condition seen");

`else

`define RHFR_ASSERT(lbl, clk, rst_n, prop)

`define RHFR_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: rtl/rhfr_pkg.sv
// ----------------------------------------------------------------------------
// rhfr_pkg
// Shared constants, result type and character helpers of the RTSP header
// frame responder.
// ----------------------------------------------------------------------------
`default_nettype none

package rhfr_pkg;

    localparam int CSEQ_CHARS  = 32;
    localparam int CNT_W       = $clog2(CSEQ_CHARS + 2);
    localparam int DATA_W      = 8;
    localparam int CFG_W       = 24;
    localparam int BODY_W      = 24;
    localparam int ACC_W       = 25;
    localparam int POS_W       = 4;
    localparam int LEN_OUT_W   = 6;
    localparam int CHARS_OUT_W = 256;
    localparam int TOTAL_W     = 64;
    localparam int TDATA_W     = 328;
    localparam int TUSER_W     = 1;

    localparam logic [ACC_W-1:0] LEN_SAT      = ACC_W'(25'h100_0000);
    localparam logic [CFG_W-1:0] MAX_BODY_RST = CFG_W'(24'h10_0000);

    localparam logic [POS_W-1:0] KEY_CSEQ_LEN = POS_W'(4);
    localparam logic [POS_W-1:0] KEY_CLEN_LEN = POS_W'(14);
    localparam logic [POS_W-1:0] POS_MAX      = POS_W'(15);

    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_COLON = 8'h3A;
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
    localparam logic [DATA_W-1:0] CH_0     = 8'h30;
    localparam logic [DATA_W-1:0] CH_9     = 8'h39;
    localparam logic [DATA_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [DATA_W-1:0] CH_UP_Z  = 8'h5A;

    typedef struct packed {
        logic                   status;
        logic [LEN_OUT_W-1:0]   cseq_length;
        logic                   cseq_truncated;
        logic [CHARS_OUT_W-1:0] cseq_chars;
        logic [TOTAL_W-1:0]     answered_total;
    } t_result;

    function automatic logic is_ws(input logic [DATA_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic [DATA_W-1:0] to_lower(input logic [DATA_W-1:0] b);
        return ((b >= CH_UP_A) && (b <= CH_UP_Z)) ? (b | 8'h20) : b;
    endfunction

    function automatic logic [DATA_W-1:0] key_cseq_char(input logic [POS_W-1:0] p);
        logic [DATA_W-1:0] c;
        case (p)
            4'd0:    c = "c";
            4'd1:    c = "s";
            4'd2:    c = "e";
            4'd3:    c = "q";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] key_clen_char(input logic [POS_W-1:0] p);
        logic [DATA_W-1:0] c;
        case (p)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rhfr_core.sv
// ----------------------------------------------------------------------------
// rhfr_core
// Per-byte header parser: line split, key match, CSeq capture, content
// length, body skip and answer or error generation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rhfr_core
    import rhfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [DATA_W-1:0] i_byte,
    input  wire logic [CFG_W-1:0]  i_max_body,
    output logic                   o_res_valid,
    output t_result                o_res
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_STOPPED
    } t_phase;

    typedef enum logic [1:0] {
        LP_KEY,
        LP_CSEQ,
        LP_LENGTH,
        LP_SKIP
    } t_part;

    localparam logic [1:0] TM_NONE    = 2'd0;
    localparam logic [1:0] TM_CR      = 2'd1;
    localparam logic [1:0] TM_CRLF    = 2'd2;
    localparam logic [1:0] TM_CRLFCR  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_CHARS = CNT_W'(CSEQ_CHARS);

    t_phase              r_phase, n_phase;
    logic [1:0]          r_tm, n_tm;
    logic                r_pending_cr, n_pending_cr;
    t_part               r_part, n_part;
    logic                r_cand_cseq, n_cand_cseq;
    logic                r_cand_clen, n_cand_clen;
    logic                r_key_started, n_key_started;
    logic                r_trailing, n_trailing;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic                r_len_started, n_len_started;
    logic                r_len_ended, n_len_ended;
    logic                r_msg_error, n_msg_error;
    logic [BODY_W-1:0]   r_body, n_body;
    logic [CNT_W-1:0]    r_kept, n_kept;
    logic                r_trunc, n_trunc;
    logic [CNT_W-1:0]    r_raw, n_raw;
    logic [CNT_W-1:0]    r_last_ns, n_last_ns;
    logic [TOTAL_W-1:0]  r_answered, n_answered;
    logic [DATA_W-1:0]   r_store [CSEQ_CHARS];

    logic                store_we;
    logic                is_cr, is_lf, ws, digit, do_answer, do_error;
    logic [DATA_W-1:0]   lc;
    logic [DATA_W-1:0]   dval;
    logic [ACC_W+3:0]    acc_next;

    assign is_cr    = (i_byte == CH_CR);
    assign is_lf    = (i_byte == CH_LF);
    assign ws       = is_ws(i_byte);
    assign digit    = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign lc       = to_lower(i_byte);
    assign dval     = i_byte - CH_0;
    assign acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + (ACC_W+4)'(dval[3:0]);

    always_comb begin
        n_phase       = r_phase;
        n_tm          = r_tm;
        n_pending_cr  = r_pending_cr;
        n_part        = r_part;
        n_cand_cseq   = r_cand_cseq;
        n_cand_clen   = r_cand_clen;
        n_key_started = r_key_started;
        n_trailing    = r_trailing;
        n_pos         = r_pos;
        n_acc         = r_acc;
        n_len_started = r_len_started;
        n_len_ended   = r_len_ended;
        n_msg_error   = r_msg_error;
        n_body        = r_body;
        n_kept        = r_kept;
        n_trunc       = r_trunc;
        n_raw         = r_raw;
        n_last_ns     = r_last_ns;
        n_answered    = r_answered;
        store_we      = 1'b0;
        do_answer     = 1'b0;
        do_error      = 1'b0;
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (i_step) begin
            case (r_phase)
                PH_BODY: begin
                    n_body = (r_body != '0) ? (r_body - BODY_W'(1)) : '0;
                    do_answer = (r_body <= BODY_W'(1));
                end
                PH_HEADER: begin
                    if (is_cr) begin
                        n_tm = (r_tm == TM_CRLF) ? TM_CRLFCR : TM_CR;
                    end else if (is_lf) begin
                        n_tm = (r_tm == TM_CR) ? TM_CRLF : TM_NONE;
                    end else begin
                        n_tm = TM_NONE;
                    end
                    n_pending_cr = is_cr;

                    if (r_pending_cr && is_lf) begin
                        case (r_part)
                            LP_CSEQ: begin
                                n_kept  = (r_last_ns > CNT_CHARS) ? CNT_CHARS : r_last_ns;
                                n_trunc = (r_last_ns > CNT_CHARS);
                            end
                            LP_LENGTH: begin
                                if (!r_len_started || (r_acc > {1'b0, i_max_body})) begin
                                    n_msg_error = 1'b1;
                                end else begin
                                    n_body = r_acc[BODY_W-1:0];
                                end
                            end
                            default: ;
                        endcase
                        n_part        = LP_KEY;
                        n_cand_cseq   = 1'b1;
                        n_cand_clen   = 1'b1;
                        n_key_started = 1'b0;
                        n_trailing    = 1'b0;
                        n_pos         = '0;
                        n_acc         = '0;
                        n_len_started = 1'b0;
                        n_len_ended   = 1'b0;
                        n_raw         = '0;
                        n_last_ns     = '0;
                    end else begin
                        case (r_part)
                            LP_KEY: begin
                                if (i_byte == CH_COLON) begin
                                    if (r_key_started && r_cand_cseq
                                        && (r_pos == KEY_CSEQ_LEN)) begin
                                        n_part = LP_CSEQ;
                                    end else if (r_key_started && r_cand_clen
                                        && (r_pos == KEY_CLEN_LEN)) begin
                                        n_part = LP_LENGTH;
                                    end else begin
                                        n_part = LP_SKIP;
                                    end
                                end else if (ws) begin
                                    if (r_key_started) begin
                                        n_trailing = 1'b1;
                                    end
                                end else begin
                                    n_key_started = 1'b1;
                                    if (r_trailing) begin
                                        n_cand_cseq = 1'b0;
                                        n_cand_clen = 1'b0;
                                    end else begin
                                        if ((r_pos >= KEY_CSEQ_LEN) || (key_cseq_char(r_pos) != lc)) begin
                                            n_cand_cseq = 1'b0;
                                        end
                                        if ((r_pos >= KEY_CLEN_LEN) || (key_clen_char(r_pos) != lc)) begin
                                            n_cand_clen = 1'b0;
                                        end
                                        if (r_pos < POS_MAX) begin
                                            n_pos = r_pos + POS_W'(1);
                                        end
                                    end
                                end
                            end
                            LP_CSEQ: begin
                                if (!(ws && (r_raw == '0))) begin
                                    store_we = (r_raw < CNT_CHARS);
                                    if (r_raw <= CNT_CHARS) begin
                                        n_raw = r_raw + CNT_W'(1);
                                    end
                                    if (!ws) begin
                                        n_last_ns = n_raw;
                                    end
                                end
                            end
                            LP_LENGTH: begin
                                if (!r_len_started) begin
                                    if (!ws) begin
                                        n_len_started = 1'b1;
                                        if (digit) begin
                                            n_acc = ACC_W'(dval[3:0]);
                                        end else begin
                                            n_len_ended = 1'b1;
                                            n_msg_error = 1'b1;
                                        end
                                    end
                                end else if (!r_len_ended) begin
                                    if (digit) begin
                                        n_acc = (acc_next > (ACC_W+4)'(LEN_SAT))
                                              ? LEN_SAT : acc_next[ACC_W-1:0];
                                    end else begin
                                        n_len_ended = 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end

                    if (is_lf && (r_tm == TM_CRLFCR)) begin
                        n_tm = TM_NONE;
                        if (r_msg_error) begin
                            do_error = 1'b1;
                        end else if (r_body == '0) begin
                            do_answer = 1'b1;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (do_error) begin
            o_res_valid          = 1'b1;
            o_res.status         = 1'b1;
            o_res.answered_total = r_answered;
            n_phase              = PH_STOPPED;
        end

        if (do_answer) begin
            n_answered           = r_answered + TOTAL_W'(1);
            o_res_valid          = 1'b1;
            o_res.status         = 1'b0;
            o_res.cseq_length    = LEN_OUT_W'(r_kept);
            o_res.cseq_truncated = r_trunc;
            o_res.answered_total = n_answered;
            for (int i = 0; i < CSEQ_CHARS; i++) begin
                if (CNT_W'(i) < r_kept) begin
                    o_res.cseq_chars[8*i +: 8] = r_store[i];
                end
            end
            n_phase       = PH_HEADER;
            n_tm          = TM_NONE;
            n_pending_cr  = 1'b0;
            n_body        = '0;
            n_msg_error   = 1'b0;
            n_kept        = '0;
            n_trunc       = 1'b0;
            n_part        = LP_KEY;
            n_cand_cseq   = 1'b1;
            n_cand_clen   = 1'b1;
            n_key_started = 1'b0;
            n_trailing    = 1'b0;
            n_pos         = '0;
            n_acc         = '0;
            n_len_started = 1'b0;
            n_len_ended   = 1'b0;
            n_raw         = '0;
            n_last_ns     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_tm          <= TM_NONE;
            r_pending_cr  <= 1'b0;
            r_part        <= LP_KEY;
            r_cand_cseq   <= 1'b1;
            r_cand_clen   <= 1'b1;
            r_key_started <= 1'b0;
            r_trailing    <= 1'b0;
            r_pos         <= '0;
            r_acc         <= '0;
            r_len_started <= 1'b0;
            r_len_ended   <= 1'b0;
            r_msg_error   <= 1'b0;
            r_body        <= '0;
            r_kept        <= '0;
            r_trunc       <= 1'b0;
            r_raw         <= '0;
            r_last_ns     <= '0;
            r_answered    <= '0;
        end else begin
            r_phase       <= n_phase;
            r_tm          <= n_tm;
            r_pending_cr  <= n_pending_cr;
            r_part        <= n_part;
            r_cand_cseq   <= n_cand_cseq;
            r_cand_clen   <= n_cand_clen;
            r_key_started <= n_key_started;
            r_trailing    <= n_trailing;
            r_pos         <= n_pos;
            r_acc         <= n_acc;
            r_len_started <= n_len_started;
            r_len_ended   <= n_len_ended;
            r_msg_error   <= n_msg_error;
            r_body        <= n_body;
            r_kept        <= n_kept;
            r_trunc       <= n_trunc;
            r_raw         <= n_raw;
            r_last_ns     <= n_last_ns;
            r_answered    <= n_answered;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CSEQ_CHARS; i++) begin
            if (store_we && (r_raw == CNT_W'(i))) begin
                r_store[i] <= i_byte;
            end
        end
    end

    `RHFR_ASSERT(a_stop_sticky, i_clk, i_rst_n, (r_phase == PH_STOPPED) |=> (r_phase == PH_STOPPED))
    `RHFR_ASSERT(a_err_stops, i_clk, i_rst_n, (o_res_valid && o_res.status) |=> (r_phase == PH_STOPPED))
    `RHFR_ASSERT(a_body_nonzero, i_clk, i_rst_n, (r_phase == PH_BODY) |-> (r_body != '0))
    `RHFR_ASSERT(a_cr_tracks_tm, i_clk, i_rst_n, r_pending_cr |-> ((r_tm == TM_CR) || (r_tm == TM_CRLFCR)))
    `RHFR_NEVER(a_kept_range, i_clk, i_rst_n, r_kept > CNT_CHARS)

endmodule

`default_nettype wire

// File: rtl/rtsp_header_frame_responder.sv
// ----------------------------------------------------------------------------
// rtsp_header_frame_responder
// RTSP header parser on a byte stream: echoes the last CSeq, skips the body
// given by Content-Length and counts answered messages.
// ----------------------------------------------------------------------------
// A taken byte goes into the input register, steps the parser, and its result is registered onto m_axis.
// Throughput: one byte per cycle; a result held on m_axis holds the parser,
// and the input stalls once the input register is full.
// Reset (i_rst_n low, synchronous) clears control state and counters and sets
// max_body to 1 MiB. The CSeq character store has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_header_frame_responder
    import rhfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // cseq_length, cseq_truncated,
                                                    // cseq_chars_0..3, answered_total, pad
    output logic [TUSER_W-1:0]      m_axis_tuser,   // [0] status
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CFG_W-1:0]   i_cfg_data      // max_body
);

    logic               r_in_valid;
    logic [DATA_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_result            r_out;
    logic [CFG_W-1:0]   r_max_body;

    logic               adv;
    logic               res_valid;
    t_result            res;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    rhfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (adv),
        .i_byte      (r_in_byte),
        .i_max_body  (r_max_body),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_body  <= MAX_BODY_RST;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_body <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {1'b0, r_out.answered_total, r_out.cseq_chars,
                            r_out.cseq_truncated, r_out.cseq_length};

endmodule

`default_nettype wire
